@@ rtl/tkrl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkrl_pkg - shared types and codes of the top-k ranked list
// Command and status codes, beat payload structs and the control bundle
// that runs between controller and datapath.
// ---------------------------------------------------------------------------
package tkrl_pkg;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_CLEAR  = 2'd1;
   localparam logic [1:0] CMD_READ   = 2'd2;

   localparam logic [2:0] STAT_INSERTED = 3'd0;
   localparam logic [2:0] STAT_REJECTED = 3'd1;
   localparam logic [2:0] STAT_CLEARED  = 3'd2;
   localparam logic [2:0] STAT_READ_OK  = 3'd3;
   localparam logic [2:0] STAT_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] loss_key;
      logic [31:0] tag;
      logic [3:0]  read_rank;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  entry_count;
      logic [3:0]  placed_rank;
      logic [31:0] out_loss;
      logic [31:0] out_tag;
   } rsp_type;

   typedef struct packed {
      logic capture;  // latch the accepted request beat
      logic eval;     // register compare vector and read data
      logic apply;    // update the list and load the response register
   } ctrl_cmd_type;

endpackage
`default_nettype wire

@@ rtl/top_k_ranked_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// top_k_ranked_list - best DEPTH candidates kept in ascending loss order
// Request beats (req_valid/req_ready, payload req_data) carry insert, clear
// or read-rank commands; each produces exactly one response beat
// (rsp_valid/rsp_ready, payload rsp_data) with status and entry count.
// Losses are IEEE single bit patterns compared as unsigned; infinity and
// NaN are rejected; ties keep arrival order.
// Each request passes three steps: capture, parallel compare of every cell
// against the candidate, and the one-place shift of the cell row; the block
// takes its next request only once the response is loaded, so it holds one
// item at a time.
// When the receiver stalls, the response register holds its beat and the
// next request is still accepted and evaluated; it waits in its apply step
// until the pending beat is taken.
// Reset clears the entry count and the control state; the cells are not
// cleared since entries past the count are never read.
// ---------------------------------------------------------------------------
module top_k_ranked_list #(
   parameter int DEPTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire tkrl_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      tkrl_pkg::rsp_type rsp_data
);
   import tkrl_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   // Sequencer: steps each beat and owns response valid
   tkrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl_cmd  (ctrl_cmd)
   );

   // Cell row, count and response register
   tkrl_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .ctrl_cmd (ctrl_cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // Drop ready for the beat after an accept: one item in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous item still in flight");

   // A fresh response beat must follow an accepted request
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 3))
      else $error("response beat without matching request");

   // Status code is always a defined one
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= STAT_EMPTY))
      else $error("undefined response status");

   // A clear reports an empty list
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STAT_CLEARED)) |-> (rsp_data.entry_count == 5'd0))
      else $error("clear left entries behind");

endmodule
`default_nettype wire

@@ rtl/tkrl_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkrl_ctrl - sequencer of the top-k ranked list
// Steps each request through evaluate and apply, and owns the response
// valid flag so a finished result waits without blocking the list.
// ---------------------------------------------------------------------------
module tkrl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      tkrl_pkg::ctrl_cmd_type ctrl_cmd
);
   import tkrl_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      ctrl_cmd.capture = 1'b0;
      ctrl_cmd.eval    = 1'b0;
      ctrl_cmd.apply   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl_cmd.capture = 1'b1;
               state_in         = S_EVAL;
            end
         end
         S_EVAL: begin
            ctrl_cmd.eval = 1'b1;
            state_in      = S_APPLY;
         end
         S_APPLY: begin
            // hold until the response register is free
            if (slot_free) begin
               ctrl_cmd.apply = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/tkrl_dpath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkrl_dpath - ranked cell row and response register
// Each cell compares its loss against the candidate in parallel; on apply
// the cells from the landing rank onward shift one place toward the tail.
// ---------------------------------------------------------------------------
module tkrl_dpath #(
   parameter int DEPTH = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tkrl_pkg::ctrl_cmd_type ctrl_cmd,
   input  wire tkrl_pkg::req_type      req_data,
   output      tkrl_pkg::rsp_type      rsp_data
);
   import tkrl_pkg::*;

   localparam int CntW = $clog2(DEPTH + 1);
   localparam int CmpW = (CntW > 4) ? CntW : 4;

   logic [31:0]     loss_ff [DEPTH];
   logic [31:0]     tag_ff  [DEPTH];
   logic [31:0]     loss_in [DEPTH];
   logic [31:0]     tag_in  [DEPTH];
   logic [CntW-1:0] count_ff;
   logic [CntW-1:0] count_in;
   req_type         req_ff;
   logic [DEPTH-1:0] gt;
   logic [DEPTH-1:0] hit_ff;
   logic [DEPTH-1:0] hit_in;
   logic [DEPTH-1:0] hit_prev;
   logic            take_ff;
   logic            take_in;
   logic            rd_ok_ff;
   logic            rd_ok_in;
   logic [31:0]     rd_loss_ff;
   logic [31:0]     rd_loss_in;
   logic [31:0]     rd_tag_ff;
   logic [31:0]     rd_tag_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;
   logic            full;
   logic            finite;
   logic            write_en;
   logic [CmpW-1:0] rank_ext;
   logic [CmpW-1:0] count_ext;
   logic [3:0]      placed;

   assign full      = (count_ff == CntW'(DEPTH));
   assign finite    = (req_ff.loss_key[30:23] != 8'hFF);
   assign rank_ext  = CmpW'(req_ff.read_rank);
   assign count_ext = CmpW'(count_ff);
   assign hit_prev  = {hit_ff[DEPTH-2:0], 1'b0};
   assign write_en  = ctrl_cmd.apply && (req_ff.cmd == CMD_INSERT) && take_ff;
   assign rsp_data  = rsp_ff;

   // Evaluate: per-cell compare, landing mask and the read mux
   always_comb begin
      rd_loss_in = '0;
      rd_tag_in  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         gt[i]     = (CntW'(i) < count_ff) && (req_ff.loss_key < loss_ff[i]);
         hit_in[i] = gt[i] || (!full && (count_ff == CntW'(i)));
         if (rank_ext == CmpW'(i)) begin
            rd_loss_in = loss_ff[i];
            rd_tag_in  = tag_ff[i];
         end
      end
      take_in  = finite && (!full || gt[DEPTH-1]);
      rd_ok_in = (rank_ext < count_ext);
   end

   // Shift: a hit cell takes its neighbor ahead, the first hit takes the new entry
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         always_comb begin
            loss_in[g] = hit_ff[g] ? req_ff.loss_key : loss_ff[g];
            tag_in[g]  = hit_ff[g] ? req_ff.tag      : tag_ff[g];
         end
      end else begin : g_body
         always_comb begin
            loss_in[g] = loss_ff[g];
            tag_in[g]  = tag_ff[g];
            if (hit_ff[g]) begin
               loss_in[g] = hit_prev[g] ? loss_ff[g-1] : req_ff.loss_key;
               tag_in[g]  = hit_prev[g] ? tag_ff[g-1]  : req_ff.tag;
            end
         end
      end
   end

   // Apply: count update and response beat
   always_comb begin
      placed = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (hit_ff[i] && !hit_prev[i]) begin
            placed = placed | 4'(i);
         end
      end
      count_in = count_ff;
      if (ctrl_cmd.apply) begin
         case (req_ff.cmd)
            CMD_INSERT: begin
               if (take_ff && !full) begin
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end

      rsp_in             = '0;
      rsp_in.status      = STAT_REJECTED;
      rsp_in.entry_count = 5'(count_in);
      case (req_ff.cmd)
         CMD_INSERT: begin
            if (take_ff) begin
               rsp_in.status      = STAT_INSERTED;
               rsp_in.placed_rank = placed;
            end
         end
         CMD_CLEAR: begin
            rsp_in.status = STAT_CLEARED;
         end
         CMD_READ: begin
            if (rd_ok_ff) begin
               rsp_in.status   = STAT_READ_OK;
               rsp_in.out_loss = rd_loss_ff;
               rsp_in.out_tag  = rd_tag_ff;
            end else begin
               rsp_in.status = STAT_EMPTY;
            end
         end
         default: begin
            rsp_in.status = STAT_REJECTED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         req_ff <= req_data;
      end
      if (ctrl_cmd.eval) begin
         hit_ff     <= hit_in;
         take_ff    <= take_in;
         rd_ok_ff   <= rd_ok_in;
         rd_loss_ff <= rd_loss_in;
         rd_tag_ff  <= rd_tag_in;
      end
      if (ctrl_cmd.apply) begin
         rsp_ff <= rsp_in;
      end
      if (write_en) begin
         for (int i = 0; i < DEPTH; i++) begin
            loss_ff[i] <= loss_in[i];
            tag_ff[i]  <= tag_in[i];
         end
      end
   end

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench - self-checking bench for the top-k ranked list
// Feeds insert, clear, read and unused command beats through the request
// channel, predicts every response beat with a local copy of the ranked
// list, and checks each response field by field in arrival order. Both
// channels idle in random bursts, and one long response stall fills the
// block so that it must back-pressure its request side.
// ---------------------------------------------------------------------------
module testbench;
   import tkrl_pkg::*;

   // Command code 3 has no action in the block and no name in the package.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int LIST_DEPTH    = 16;
   localparam int ITEM_TARGET   = 650;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 12;
   localparam int HOLD_CYCLES   = 400;
   localparam int HOLD_AFTER    = 120;

   // ------------------------------------------------------------------------
   // Clock, reset and the block's ports. Every input has a known value
   // from time zero.
   // ------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   top_k_ranked_list #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Shared bench state
   // ------------------------------------------------------------------------
   req_type queued_cmds[$];      // request beats not yet offered
   rsp_type pending_rsp[$];      // predicted responses, oldest first
   int      planned_items  = 0;
   int      accepted_count = 0;
   int      received_count = 0;
   int      error_count    = 0;
   int      cycle_count    = 0;
   int      send_gap       = 0;
   int      recv_gap       = 0;
   logic    hold_rsp       = 1'b0;
   rsp_type rsp_want;

   // Local copy of the ranked list, best entry at index 0.
   logic [31:0] list_loss[LIST_DEPTH];
   logic [31:0] list_tag[LIST_DEPTH];
   int          list_count = 0;

   // ------------------------------------------------------------------------
   // Predictor: apply one command to the local list and return the
   // response the block must send for it.
   // ------------------------------------------------------------------------
   function automatic rsp_type ranked_list_response(req_type beat);
      rsp_type res;
      int      pos;
      logic    take;
      res        = '0;
      res.status = STAT_REJECTED;
      take       = 1'b0;
      pos        = 0;
      case (beat.cmd)
         CMD_INSERT: begin
            // Infinity and NaN carry an all-ones exponent: drop them.
            if (beat.loss_key[30:23] != 8'hFF) begin
               if (list_count < LIST_DEPTH) begin
                  pos        = list_count;
                  list_count = list_count + 1;
                  take       = 1'b1;
               end else if (beat.loss_key < list_loss[LIST_DEPTH-1]) begin
                  // Full list: evict the worst only on a strictly better loss.
                  pos  = LIST_DEPTH - 1;
                  take = 1'b1;
               end
            end
            if (take) begin
               // Move ahead of strictly worse entries only, so ties keep order.
               while (pos > 0 && beat.loss_key < list_loss[pos-1]) begin
                  list_loss[pos] = list_loss[pos-1];
                  list_tag[pos]  = list_tag[pos-1];
                  pos            = pos - 1;
               end
               list_loss[pos]  = beat.loss_key;
               list_tag[pos]   = beat.tag;
               res.placed_rank = pos[3:0];
               res.status      = STAT_INSERTED;
            end
         end
         CMD_CLEAR: begin
            list_count = 0;
            res.status = STAT_CLEARED;
         end
         CMD_READ: begin
            if (int'(beat.read_rank) < list_count) begin
               res.out_loss = list_loss[beat.read_rank];
               res.out_tag  = list_tag[beat.read_rank];
               res.status   = STAT_READ_OK;
            end else begin
               res.status = STAT_EMPTY;
            end
         end
         default: ;
      endcase
      res.entry_count = list_count[4:0];
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_cmd(logic [1:0] cmd, logic [31:0] loss, logic [31:0] tag,
                            logic [3:0] rank);
      req_type beat;
      beat.cmd       = cmd;
      beat.loss_key  = loss;
      beat.tag       = tag;
      beat.read_rank = rank;
      queued_cmds.push_back(beat);
   endtask

   // Mostly finite positive losses; a small pool forces ties, and a share
   // of raw patterns brings in negative, infinite and NaN keys.
   function automatic logic [31:0] pick_loss();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         return 32'h3F80_0000 + $urandom_range(0, 5);
      end else if (sel < 75) begin
         return {1'b0, 8'($urandom_range(0, 254)), 23'($urandom)};
      end else if (sel < 92) begin
         return $urandom;
      end else if (sel < 95) begin
         return 32'h0000_0000;
      end else if (sel < 98) begin
         return 32'h7F7F_FFFF;
      end
      return 32'hFFFF_FFFF;
   endfunction

   // Idling is off for a stretch in the middle and over the last part.
   function automatic logic idling_allowed();
      if (accepted_count >= 250 && accepted_count < 330)
         return 1'b0;
      return accepted_count < planned_items - 100;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count = error_count + 1;
      $display("mismatch on response %0d: %s got 0x%08h want 0x%08h",
               received_count, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus: a short directed part, then random episodes.
   // ------------------------------------------------------------------------
   initial begin
      int steps;
      int sel;

      // Empty list and the unused command code.
      queue_cmd(CMD_READ,   32'h0,         32'h0,         4'd0);
      queue_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      // Non-finite losses: infinities and NaNs of both signs.
      queue_cmd(CMD_INSERT, 32'h7F80_0000, 32'h1111_1111, 4'd0);
      queue_cmd(CMD_INSERT, 32'h7FC0_0001, 32'h2222_2222, 4'd0);
      queue_cmd(CMD_INSERT, 32'hFF80_0000, 32'h3333_3333, 4'd0);
      queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h4444_4444, 4'd0);
      // Field extremes, a sign-set zero that ranks as very large, and a tie.
      queue_cmd(CMD_INSERT, 32'h7F7F_FFFF, 32'h0000_0000, 4'hF);
      queue_cmd(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 4'd0);
      queue_cmd(CMD_INSERT, 32'h8000_0000, 32'hA5A5_A5A5, 4'd0);
      queue_cmd(CMD_INSERT, 32'h3F80_0000, 32'h0000_0001, 4'd0);
      queue_cmd(CMD_INSERT, 32'h3F80_0000, 32'h0000_0002, 4'd0);
      queue_cmd(CMD_INSERT, 32'h0080_0000, 32'h5A5A_5A5A, 4'd0);
      for (int r = 0; r < 6; r++)
         queue_cmd(CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'(r));
      // Reads past the valid entries.
      queue_cmd(CMD_READ,   32'h0,         32'h0,         4'd6);
      queue_cmd(CMD_READ,   32'h0,         32'h0,         4'hF);
      queue_cmd(CMD_CLEAR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
      queue_cmd(CMD_READ,   32'h0,         32'h0,         4'd0);
      queue_cmd(CMD_INSERT, 32'h7F7F_FFFF, 32'h5A5A_5A5A, 4'hF);
      queue_cmd(CMD_READ,   32'h0,         32'h0,         4'd0);
      queue_cmd(CMD_CLEAR,  32'h0,         32'h0,         4'd0);

      // Random episodes: usually start from an empty list, then a burst of 4 to 40
      // commands, at the long end enough to fill it and exercise eviction, with reads mixed in.
      while (queued_cmds.size() < ITEM_TARGET) begin
         if ($urandom_range(0, 3) != 0)
            queue_cmd(CMD_CLEAR, $urandom, $urandom, 4'($urandom));
         steps = $urandom_range(4, 40);
         for (int i = 0; i < steps; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 62)
               queue_cmd(CMD_INSERT, pick_loss(), $urandom, 4'($urandom));
            else if (sel < 94)
               queue_cmd(CMD_READ, $urandom, $urandom, 4'($urandom));
            else if (sel < 97)
               queue_cmd(CMD_UNUSED, $urandom, $urandom, 4'($urandom));
            else
               queue_cmd(CMD_CLEAR, $urandom, $urandom, 4'($urandom));
         end
      end
      planned_items = queued_cmds.size();

      // Wait for every beat to be taken and answered, then drain a little
      // longer so that a stray response beat is still caught.
      wait (accepted_count == planned_items && received_count == accepted_count);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Long receiver stall: hold rsp_ready low while requests keep coming,
   // so the block fills and must lower req_ready.
   // ------------------------------------------------------------------------
   initial begin
      wait (accepted_count >= HOLD_AFTER);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // ------------------------------------------------------------------------
   // Driver: predict on every accepted beat, then hold, idle or advance.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && req_ready) begin
            pending_rsp.push_back(ranked_list_response(req_data));
            accepted_count = accepted_count + 1;
            if (idling_allowed() && $urandom_range(0, 5) == 0)
               send_gap = $urandom_range(1, 12);
         end
         if (req_valid && !req_ready) begin
            // Hold the beat until the block takes it.
         end else if (send_gap > 0) begin
            send_gap  = send_gap - 1;
            req_valid <= 1'b0;
         end else if (queued_cmds.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= queued_cmds.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each response beat against the oldest prediction and
   // decide the next rsp_ready.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            received_count = received_count + 1;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected beat, status", 32'(rsp_data.status), 32'h0);
            end else begin
               rsp_want = pending_rsp.pop_front();
               if (rsp_data.status !== rsp_want.status)
                  report_mismatch("status", 32'(rsp_data.status), 32'(rsp_want.status));
               if (rsp_data.entry_count !== rsp_want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_data.entry_count),
                                  32'(rsp_want.entry_count));
               if (rsp_data.placed_rank !== rsp_want.placed_rank)
                  report_mismatch("placed_rank", 32'(rsp_data.placed_rank),
                                  32'(rsp_want.placed_rank));
               if (rsp_data.out_loss !== rsp_want.out_loss)
                  report_mismatch("out_loss", rsp_data.out_loss, rsp_want.out_loss);
               if (rsp_data.out_tag !== rsp_want.out_tag)
                  report_mismatch("out_tag", rsp_data.out_tag, rsp_want.out_tag);
            end
         end
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap  = recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (idling_allowed() && $urandom_range(0, 7) == 0)
               recv_gap = $urandom_range(1, 12);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end a hung run.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

endmodule
